// File: hw/rtl/sasp_pkg.sv
// shared types for the sweep active-set pair emitter
`timescale 1ns / 1ps

package sasp_pkg;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // input transfer taken, latch the edge
        logic advance;    // scan moves on to the next slot
        logic capture;    // current slot pair goes into the pending register
        logic push_mid;   // pending pair moves to the output, not the last one
        logic push_last;  // pending pair moves to the output as the last one
        logic finish;     // update the active set, edge done
    } ctrl_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic hit;        // current slot is occupied and the edge is a min edge
        logic pend_vld;   // a pair waits in the pending register
        logic out_free;   // output register can take a pair this cycle
        logic last_slot;  // scan stands on the highest slot
    } ctrl_status_t;

endpackage

// File: hw/rtl/sasp_ram.sv
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module sasp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hw/rtl/sasp_ctrl.sv
// controller state machine for the sweep active-set pair emitter
`timescale 1ns / 1ps

module sasp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  sasp_pkg::ctrl_status_t status,
    output sasp_pkg::ctrl_cmd_t   cmd
);

    import sasp_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       stall;

    // the scan stops when a second pair meets a full output register
    assign stall = status.hit && status.pend_vld && !status.out_free;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    cmd.advance  = 1'b1;
                    cmd.capture  = status.hit;
                    cmd.push_mid = status.hit && status.pend_vld;
                    if (status.last_slot) begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (!status.pend_vld || status.out_free) begin
                    cmd.finish    = 1'b1;
                    cmd.push_last = status.pend_vld;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/sasp_datapath.sv
// datapath: active slots, slot scan, pending pair and output register
`timescale 1ns / 1ps

module sasp_datapath #(
    parameter int MAX_ACTIVE = 32,
    parameter int ID_WIDTH   = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sasp_pkg::ctrl_cmd_t    cmd,
    output sasp_pkg::ctrl_status_t status,
    input  logic                   in_start,
    input  logic [ID_WIDTH-1:0]    in_id,
    input  logic                   in_min,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [ID_WIDTH-1:0]    out_entering,
    output logic [ID_WIDTH-1:0]    out_overlapping,
    output logic                   m_tlast,
    output logic                   m_tuser
);

    import sasp_pkg::*;

    localparam int IDX_W = $clog2(MAX_ACTIVE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ACTIVE - 1);

    logic [IDX_W-1:0]      cur_reg;
    logic [IDX_W-1:0]      cur_next;
    logic [ID_WIDTH-1:0]   id_reg;
    logic                  min_reg;
    logic [MAX_ACTIVE-1:0] valid_reg;
    logic [MAX_ACTIVE-1:0] valid_next;
    logic                  found_reg;
    logic [IDX_W-1:0]      match_reg;
    logic                  free_found_reg;
    logic [IDX_W-1:0]      free_reg;
    logic                  pend_vld_reg;
    logic [ID_WIDTH-1:0]   pend_id_reg;
    logic                  out_vld_reg;
    logic [ID_WIDTH-1:0]   out_ent_reg;
    logic [ID_WIDTH-1:0]   out_ovl_reg;
    logic                  out_last_reg;
    logic                  out_ov_reg;
    logic [ID_WIDTH-1:0]   slot_rd;
    logic                  slot_valid;
    logic                  id_match;
    logic                  do_insert;
    logic                  dropped;

    // slot under scan
    assign slot_valid = valid_reg[cur_reg];
    assign id_match   = slot_valid && (slot_rd == id_reg);
    assign do_insert  = min_reg && !found_reg && free_found_reg;
    assign dropped    = min_reg && !found_reg && !free_found_reg;

    assign status.hit       = min_reg && slot_valid;
    assign status.pend_vld  = pend_vld_reg;
    assign status.out_free  = !out_vld_reg || m_tready;
    assign status.last_slot = (cur_reg == LAST_IDX);

    // scan index; its next value is the ram read address, so the read data belongs to the registered index
    always_comb begin
        cur_next = cur_reg;
        if (cmd.advance) begin
            cur_next = (cur_reg == LAST_IDX) ? '0 : cur_reg + 1'b1;
        end
    end

    // slot ids
    sasp_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (MAX_ACTIVE)
    ) u_slot_ram (
        .clk     (aclk),
        .wr_en   (cmd.finish && do_insert),
        .wr_addr (free_reg),
        .wr_data (id_reg),
        .rd_addr (cur_next),
        .rd_data (slot_rd)
    );

    // occupancy update: clear on sweep start, insert or remove at the end
    always_comb begin
        valid_next = valid_reg;
        if (cmd.load && in_start) begin
            valid_next = '0;
        end
        if (cmd.finish) begin
            if (do_insert) begin
                valid_next[free_reg] = 1'b1;
            end
            if (!min_reg && found_reg) begin
                valid_next[match_reg] = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg        <= '0;
            valid_reg      <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            pend_vld_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
        end else begin
            cur_reg   <= cur_next;
            valid_reg <= valid_next;
            if (cmd.load) begin
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                pend_vld_reg   <= 1'b0;
            end else if (cmd.advance) begin
                if (id_match && !found_reg) begin
                    found_reg <= 1'b1;
                end
                if (!slot_valid && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                end
                if (cmd.capture) begin
                    pend_vld_reg <= 1'b1;
                end
            end else if (cmd.push_last) begin
                pend_vld_reg <= 1'b0;
            end
            if (cmd.push_mid || cmd.push_last) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            id_reg  <= in_id;
            min_reg <= in_min;
        end
        if (cmd.advance && id_match && !found_reg) begin
            match_reg <= cur_reg;
        end
        if (cmd.advance && !slot_valid && !free_found_reg) begin
            free_reg <= cur_reg;
        end
        if (cmd.capture) begin
            pend_id_reg <= slot_rd;
        end
        if (cmd.push_mid || cmd.push_last) begin
            out_ent_reg  <= id_reg;
            out_ovl_reg  <= pend_id_reg;
            out_last_reg <= cmd.push_last;
            out_ov_reg   <= cmd.push_last && dropped;
        end
    end

    assign m_tvalid        = out_vld_reg;
    assign out_entering    = out_ent_reg;
    assign out_overlapping = out_ovl_reg;
    assign m_tlast         = out_last_reg;
    assign m_tuser         = out_ov_reg;

endmodule

// File: hw/rtl/sweep_active_set_pair_emitter.sv
// top level of the sweep-and-prune active-set pair emitter
//
// Input stream: one interval edge per transfer, sorted along the sweep axis.
//   s_tdata holds the object id, s_tuser bit 0 starts a new sweep (the
//   active set is emptied first) and bit 1 marks a min edge.
// Output stream: one pair per transfer, entering id and active id in
//   m_tdata; m_tlast marks the final pair of a min edge and m_tuser flags
//   that the set was full and the entering id was dropped.
// A min edge gives one pair for each occupied slot in ascending slot order,
//   then takes the lowest free slot unless its id is already active.
//   A max edge removes its id and gives no pair.
// Each edge is handled in order: take the transfer, scan each slot of
//   the slot ram in turn (one read a cycle, held while the scan stalls),
//   then update the set. s_tready is high only between edges. A pair
//   waits in a pending register until the scan meets the next occupied
//   slot or ends, then goes to the output register once it has room.
// A stalled receiver holds the scan when the output and pending registers
//   both hold a pair and another occupied slot comes up; nothing is lost.
//   Reset empties the active set and clears the output register.
`timescale 1ns / 1ps

module sweep_active_set_pair_emitter #(
    parameter int MAX_ACTIVE = 32,
    parameter int ID_WIDTH   = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((ID_WIDTH + 7) / 8) * 8-1:0]   s_tdata,   // object_id
    input  logic [1:0]                           s_tuser,   // start_sweep, is_min_edge
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((2 * ID_WIDTH + 7) / 8) * 8-1:0] m_tdata, // entering_id, overlapping_id
    output logic                                 m_tlast,   // last_pair
    output logic                                 m_tuser    // overflow
);

    import sasp_pkg::*;

    localparam int OUT_DATA_W = ((2 * ID_WIDTH + 7) / 8) * 8;

    ctrl_cmd_t           cmd;
    ctrl_status_t        status;
    logic [ID_WIDTH-1:0] out_entering;
    logic [ID_WIDTH-1:0] out_overlapping;

    // controller
    sasp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    sasp_datapath #(
        .MAX_ACTIVE (MAX_ACTIVE),
        .ID_WIDTH   (ID_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .in_start        (s_tuser[0]),
        .in_id           (s_tdata[ID_WIDTH-1:0]),
        .in_min          (s_tuser[1]),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .out_entering    (out_entering),
        .out_overlapping (out_overlapping),
        .m_tlast         (m_tlast),
        .m_tuser         (m_tuser)
    );

    // pack the pair, zero filled to whole bytes
    assign m_tdata = OUT_DATA_W'({out_overlapping, out_entering});

endmodule

// File: hw/rtl/sasp_checker.sv
// port-level checker for the sweep active-set pair emitter, with its bind
`timescale 1ns / 1ps

module sasp_checker #(
    parameter int ID_WIDTH = 16
) (
    input logic                                    aclk,
    input logic                                    aresetn,
    input logic                                    s_tvalid,
    input logic                                    s_tready,
    input logic                                    m_tvalid,
    input logic                                    m_tready,
    input logic [((2 * ID_WIDTH + 7) / 8) * 8-1:0] m_tdata,
    input logic                                    m_tlast,
    input logic                                    m_tuser
);

    // a stalled output transfer keeps its pair
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output pair changed while stalled");

    // overflow only rides on the last pair of an edge
    a_ovf_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("overflow flag on a pair that is not last");

    // one edge at a time: input closes right after a transfer
    a_one_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again before the edge was handled");

    // reset empties the output register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind sweep_active_set_pair_emitter sasp_checker #(
    .ID_WIDTH (ID_WIDTH)
) u_sasp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
